[sv/sha256_hash_engine_core_defines.svh]
// Assertion macros for the SHA-256 hash engine.
// Each macro checks one property on the rising edge of i_clk while reset is inactive.
`ifndef SHA256_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA256_HASH_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SHA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sha256 check failed");
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sha256 check failed");
`else
`define SHA_ASSERT_NOW(lbl, ante, cons)
`define SHA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/sha256_pkg.sv]
package sha256_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_FOLD  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    localparam logic [31:0] PAD_MARKER = 32'h8000_0000;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    // Initial chaining value H0..H7.
    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    // Round constants K0..K63.
    function automatic logic [31:0] round_const(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

[sv/sha256_hash_engine_core.sv]
// A non-final word that does not complete a block leaves the engine ready; the word that
// completes a block loads the working variables, then 64 rounds and a fold run before the
// next is taken. After the last word, 2 to 18 padding words and one or two compressions run,
// then the eight digest words leave one per accepted output transaction.
// A single round unit serves every round, so no word is taken while a block compresses.
// Reset (synchronous, active low) loads the initial hash values and empties the block.
`include "sha256_hash_engine_core_defines.svh"

module sha256_hash_engine_core
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_state      r_state;
    logic [31:0] r_chain [8];
    logic [31:0] r_wv [8];
    logic [31:0] r_win [16];
    logic [3:0]  r_blk_cnt;
    logic [63:0] r_bit_len;
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    logic        r_padding;
    logic        r_marker_pend;
    logic        r_hi_done;
    logic        r_lo_done;

    logic        in_acc;
    logic        out_acc;
    logic [2:0]  vb_clamp;
    logic [31:0] last_word_val;
    logic [31:0] pad_word;
    logic [31:0] sched_word;
    logic [31:0] round_word;
    logic [31:0] push_word;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch_v;
    logic [31:0] maj_v;
    logic [63:0] len_add;

    assign in_acc  = i_in_valid & o_in_ready;
    assign out_acc = o_out_valid & i_out_ready;

    // Handshake and digest output.
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    // Byte count of the incoming word, with counts above four taken as full.
    assign vb_clamp = (i_valid_bytes > FULL_BYTES) ? FULL_BYTES : i_valid_bytes;

    // Final word: clear unused bytes and put the marker after the data, unless the word is full.
    always_comb begin
        case (vb_clamp)
            3'd0:    last_word_val = PAD_MARKER;
            3'd1:    last_word_val = {i_data_word[31:24], 24'h800000};
            3'd2:    last_word_val = {i_data_word[31:16], 16'h8000};
            3'd3:    last_word_val = {i_data_word[31:8], 8'h80};
            default: last_word_val = i_data_word;
        endcase
    end

    // Length increment in bits: a full word for non-final words, else eight per valid byte.
    assign len_add = (i_last) ? {58'd0, vb_clamp, 3'b000} : 64'd32;

    // Padding word: pending marker, zeros, then the 64-bit length in the last two slots.
    always_comb begin
        if (r_marker_pend) begin
            pad_word = PAD_MARKER;
        end else if (r_blk_cnt == 4'd14) begin
            pad_word = r_bit_len[63:32];
        end else if (r_blk_cnt == 4'd15 && r_hi_done) begin
            pad_word = r_bit_len[31:0];
        end else begin
            pad_word = 32'd0;
        end
    end

    // Message schedule expansion from the fixed taps of the window.
    assign sched_word = small_sig1(r_win[14]) + r_win[9] + small_sig0(r_win[1]) + r_win[0];
    assign round_word = (r_round < 6'd16) ? r_win[0] : sched_word;

    // Shared round unit.
    assign ch_v  = (r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]);
    assign maj_v = (r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]);
    assign t1    = r_wv[7] + big_sig1(r_wv[4]) + ch_v + round_const(r_round) + round_word;
    assign t2    = big_sig0(r_wv[0]) + maj_v;

    // Word shifted into the schedule window this cycle.
    always_comb begin
        case (r_state)
            S_IDLE:  push_word = (i_last) ? last_word_val : i_data_word;
            S_PAD:   push_word = pad_word;
            default: push_word = round_word;
        endcase
    end

    // Schedule window: a shift line, loaded by message and pad words and rolled in rounds.
    always_ff @(posedge i_clk) begin
        if (in_acc || r_state == S_PAD || r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= push_word;
        end
    end

    // Working variables: loaded from the chain at block start, one round per cycle.
    always_ff @(posedge i_clk) begin
        if ((in_acc || r_state == S_PAD) && r_blk_cnt == 4'd15) begin
            for (int i = 0; i < 8; i++) begin
                r_wv[i] <= r_chain[i];
            end
        end else if (r_state == S_ROUND) begin
            r_wv[7] <= r_wv[6];
            r_wv[6] <= r_wv[5];
            r_wv[5] <= r_wv[4];
            r_wv[4] <= r_wv[3] + t1;
            r_wv[3] <= r_wv[2];
            r_wv[2] <= r_wv[1];
            r_wv[1] <= r_wv[0];
            r_wv[0] <= t1 + t2;
        end
    end

    // Sequencer, chaining state and length counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_blk_cnt     <= 4'd0;
            r_bit_len     <= 64'd0;
            r_round       <= 6'd0;
            r_idx         <= 3'd0;
            r_padding     <= 1'b0;
            r_marker_pend <= 1'b0;
            r_hi_done     <= 1'b0;
            r_lo_done     <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_blk_cnt <= r_blk_cnt + 4'd1;
                        r_bit_len <= r_bit_len + len_add;
                        r_round   <= 6'd0;
                        if (i_last) begin
                            r_padding     <= 1'b1;
                            r_marker_pend <= (vb_clamp == FULL_BYTES);
                        end
                        if (r_blk_cnt == 4'd15) begin
                            r_state <= S_ROUND;
                        end else if (i_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_blk_cnt <= r_blk_cnt + 4'd1;
                    r_round   <= 6'd0;
                    if (r_marker_pend) begin
                        r_marker_pend <= 1'b0;
                    end else if (r_blk_cnt == 4'd14) begin
                        r_hi_done <= 1'b1;
                    end else if (r_blk_cnt == 4'd15 && r_hi_done) begin
                        r_lo_done <= 1'b1;
                    end
                    if (r_blk_cnt == 4'd15) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_wv[i];
                    end
                    r_idx <= 3'd0;
                    if (r_lo_done) begin
                        r_state <= S_OUT;
                    end else if (r_padding) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state       <= S_IDLE;
                            r_bit_len     <= 64'd0;
                            r_blk_cnt     <= 4'd0;
                            r_padding     <= 1'b0;
                            r_marker_pend <= 1'b0;
                            r_hi_done     <= 1'b0;
                            r_lo_done     <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_chain[i] <= init_hash(3'(i));
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The last round always hands over to the fold step.
    `SHA_ASSERT_NEXT(a_round_to_fold, (r_state == S_ROUND && r_round == 6'd63), (r_state == S_FOLD))
    // The digest is shown only after the length has gone into a full block.
    `SHA_ASSERT_NOW(a_out_after_len, (r_state == S_OUT), (r_blk_cnt == 4'd0 && r_lo_done))
    // A sixteenth message word starts a compression at round zero.
    `SHA_ASSERT_NEXT(a_block_starts, (in_acc && r_blk_cnt == 4'd15), (r_state == S_ROUND && r_round == 6'd0))
    // Taking the final digest word restarts with an empty message.
    `SHA_ASSERT_NEXT(a_restart, (out_acc && o_last_word), (r_state == S_IDLE && r_bit_len == 64'd0))

endmodule
